// ===== src/imt_pkg.sv =====
// Shared types and constants for the IRC message tokenizer.
// Used by imt_core, imt_in_reg, imt_out_reg and irc_message_tokenizer.
package imt_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned KindW      = 3;
  localparam int unsigned ParamNumW  = 4;
  localparam int unsigned MaxParamsDefault = 15;

  localparam logic [ByteW-1:0] CharColon = 8'h3A;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharBang  = 8'h21;
  localparam logic [ByteW-1:0] CharAt    = 8'h40;

  typedef enum logic [KindW-1:0] {
    KIND_SEP   = 3'd0,
    KIND_SRC   = 3'd1,
    KIND_USER  = 3'd2,
    KIND_HOST  = 3'd3,
    KIND_CMD   = 3'd4,
    KIND_MID   = 3'd5,
    KIND_TRAIL = 3'd6
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0]     data_byte;
    logic                 line_end;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]     out_byte;
    kind_e                field_kind;
    logic [ParamNumW-1:0] param_number;
    logic                 field_start;
    logic                 source_is_nick;
    logic                 malformed;
    logic                 last;
  } result_t;

endpackage

// ===== src/imt_in_reg.sv =====
// Input register stage of the tokenizer: holds one accepted byte.
// Depends on imt_pkg.
module imt_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  imt_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output imt_pkg::in_item_t item_o
);
  import imt_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== src/imt_core.sv =====
// Parse state and per-byte tagging logic of the tokenizer.
// Depends on imt_pkg. State advances once per transaction passed on (advance_i).
module imt_core #(
  parameter int unsigned MaxParams = imt_pkg::MaxParamsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  imt_pkg::in_item_t item_i,
  output imt_pkg::result_t  result_o
);
  import imt_pkg::*;

  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxParams);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_SRC   = 3'd1,
    PH_USER  = 3'd2,
    PH_HOST  = 3'd3,
    PH_CMD   = 3'd4,
    PH_PARAM = 3'd5,
    PH_TRAIL = 3'd6
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            afs_q, afs_d;
  logic            err_q, err_d;

  logic [ByteW-1:0]     b;
  logic                 handled;
  kind_e                kind;
  logic [ParamNumW-1:0] pnum;
  logic                 fs;
  logic                 nick;

  assign b = item_i.data_byte;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    afs_d   = afs_q;
    err_d   = err_q;
    kind    = KIND_SEP;
    pnum    = '0;
    fs      = 1'b0;
    nick    = 1'b0;
    handled = 1'b0;

    // line start: an optional colon opens the prefix
    if (phase_q == PH_START) begin
      afs_d = 1'b1;
      if (b == CharColon) begin
        phase_d = PH_SRC;
        handled = 1'b1;
      end else begin
        phase_d = PH_CMD;
      end
    end

    if (!handled) begin
      case (phase_d)
        PH_SRC: begin
          if (b == CharBang || b == CharSpace) begin
            nick    = (b == CharBang);
            err_d   = err_d | afs_d;
            phase_d = (b == CharBang) ? PH_USER : PH_CMD;
            afs_d   = 1'b1;
          end else begin
            kind = KIND_SRC; fs = afs_d; afs_d = 1'b0;
          end
        end
        PH_USER: begin
          if (b == CharAt) begin
            err_d = err_d | afs_d; phase_d = PH_HOST; afs_d = 1'b1;
          end else begin
            kind = KIND_USER; fs = afs_d; afs_d = 1'b0;
          end
        end
        PH_HOST: begin
          if (b == CharSpace) begin
            err_d = err_d | afs_d; phase_d = PH_CMD; afs_d = 1'b1;
          end else begin
            kind = KIND_HOST; fs = afs_d; afs_d = 1'b0;
          end
        end
        PH_CMD: begin
          if (b == CharSpace) begin
            err_d = err_d | afs_d; phase_d = PH_PARAM; afs_d = 1'b1;
          end else begin
            kind = KIND_CMD; fs = afs_d; afs_d = 1'b0;
          end
        end
        PH_PARAM: begin
          if (afs_d && b == CharColon) begin
            if (cnt_d >= MaxCnt) err_d = 1'b1;
            phase_d = PH_TRAIL;
            afs_d   = 1'b1;
          end else if (b == CharSpace) begin
            // repeated spaces count no empty parameter; index saturates
            if (!afs_d && cnt_d < MaxCnt) cnt_d = cnt_d + CntW'(1);
            afs_d = 1'b1;
          end else begin
            if (afs_d && cnt_d >= MaxCnt) err_d = 1'b1;
            kind = KIND_MID; pnum = ParamNumW'(cnt_d); fs = afs_d; afs_d = 1'b0;
          end
        end
        PH_TRAIL: begin
          kind = KIND_TRAIL; pnum = ParamNumW'(cnt_d); fs = afs_d; afs_d = 1'b0;
        end
        default: begin
          phase_d = PH_START;
          afs_d   = 1'b1;
        end
      endcase
    end

    // line ended inside the prefix or before any command byte
    if (item_i.line_end) begin
      if (phase_d == PH_SRC || phase_d == PH_USER || phase_d == PH_HOST ||
          (phase_d == PH_CMD && afs_d)) begin
        err_d = 1'b1;
      end
    end

    result_o.out_byte       = b;
    result_o.field_kind     = kind;
    result_o.param_number   = pnum;
    result_o.field_start    = fs;
    result_o.source_is_nick = nick;
    result_o.malformed      = err_d;
    result_o.last           = item_i.line_end;

    if (item_i.line_end) begin
      phase_d = PH_START;
      cnt_d   = '0;
      afs_d   = 1'b1;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
      afs_q   <= 1'b1;
      err_q   <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      afs_q   <= afs_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== src/imt_out_reg.sv =====
// Result register stage of the tokenizer: holds one tagged byte until taken.
// Depends on imt_pkg.
module imt_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  imt_pkg::result_t result_i,
  output logic             valid_o,
  input  logic             ready_i,
  output imt_pkg::result_t result_o
);
  import imt_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

// ===== src/irc_message_tokenizer.sv =====
// IRC message tokenizer top level: input register, parse logic, result register.
// Depends on imt_pkg, imt_in_reg, imt_core and imt_out_reg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one byte of an IRC line per
//   transaction, with line_end_i high on the final byte. Output channel
//   (out_valid_o/out_ready_i) returns exactly one tagged result per byte,
//   in order: the byte, its field kind, parameter index, field start,
//   nick/server flag on the source separator, running malformed flag and
//   last. Parser state returns to line start after each last byte.
//   Path: each byte passes the input register, the parse logic and the result
//   register, which holds the tagged result until it is taken.
//   Throughput: 1 byte per cycle while out_ready_i is high; each stage takes a
//   new transaction whenever it is empty or hands its item on in the same cycle.
//   Stall: when out_ready_i is low the result holds, the input register
//   fills, and in_ready_o drops until the result is taken.
//   Reset (rst_ni low, async): both stages empty, parser at line start.
module irc_message_tokenizer #(
  parameter int unsigned MaxParams = imt_pkg::MaxParamsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [imt_pkg::ByteW-1:0]        data_byte_i,
  input  logic                             line_end_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [imt_pkg::ByteW-1:0]        out_byte_o,
  output logic [imt_pkg::KindW-1:0]        field_kind_o,
  output logic [imt_pkg::ParamNumW-1:0]    param_number_o,
  output logic                             field_start_o,
  output logic                             source_is_nick_o,
  output logic                             malformed_o,
  output logic                             last_o
);
  import imt_pkg::*;

  in_item_t in_item, stage_item;
  logic     stage_valid, core_ready, advance;
  result_t  core_result, out_result;

  assign in_item.data_byte = data_byte_i;
  assign in_item.line_end  = line_end_i;

  imt_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (core_ready),
    .item_o  (stage_item)
  );

  assign advance = stage_valid && core_ready;

  imt_core #(
    .MaxParams (MaxParams)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .result_o  (core_result)
  );

  imt_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .ready_o  (core_ready),
    .result_i (core_result),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign out_byte_o       = out_result.out_byte;
  assign field_kind_o     = out_result.field_kind;
  assign param_number_o   = out_result.param_number;
  assign field_start_o    = out_result.field_start;
  assign source_is_nick_o = out_result.source_is_nick;
  assign malformed_o      = out_result.malformed;
  assign last_o           = out_result.last;

  // separators never start a field
  a_sep_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_start_o |-> field_kind_o != KIND_SEP)
    else $error("field start flagged on a separator");

  a_nick_on_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && source_is_nick_o |-> field_kind_o == KIND_SEP && out_byte_o == CharBang)
    else $error("nick flag on a byte other than the bang separator");

  // only parameter bytes carry an index
  a_pnum_params_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o != KIND_MID && field_kind_o != KIND_TRAIL
      |-> param_number_o == '0)
    else $error("parameter index on a non-parameter byte");

  // a stalled result blocks the core so no parse step is lost
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !advance)
    else $error("parse state advanced while the result register was full");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for irc_message_tokenizer: random and directed IRC lines,
// tags predicted per byte and compared with every result. Depends on imt_pkg.
module testbench;
  import imt_pkg::*;

  localparam int unsigned MaxParams = MaxParamsDefault;

  typedef enum logic [2:0] {
    PH_START, PH_SRC, PH_USER, PH_HOST, PH_CMD, PH_PARAM, PH_TRAIL
  } parse_phase_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     data_byte_i = '0;
  logic                 line_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ByteW-1:0]     out_byte_o;
  logic [KindW-1:0]     field_kind_o;
  logic [ParamNumW-1:0] param_number_o;
  logic                 field_start_o;
  logic                 source_is_nick_o;
  logic                 malformed_o;
  logic                 last_o;

  irc_message_tokenizer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .line_end_i,
    .out_valid_o, .out_ready_i, .out_byte_o, .field_kind_o, .param_number_o,
    .field_start_o, .source_is_nick_o, .malformed_o, .last_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // line parser mirror
  parse_phase_e parse_ph = PH_START;
  int unsigned  param_cnt = 0;
  logic         at_start = 1'b1;
  logic         line_err = 1'b0;

  in_item_t    line_bytes_q[$];
  result_t     expected_tags_q[$];
  logic [7:0]  text_q[$];
  in_item_t    next_byte;
  result_t     want_res;
  int unsigned err_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void close_field(parse_phase_e nxt);
    if (at_start) line_err = 1'b1;
    parse_ph = nxt;
    at_start = 1'b1;
  endfunction

  function automatic void mark_field(inout result_t r, input kind_e k);
    r.field_kind  = k;
    r.field_start = at_start;
    at_start      = 1'b0;
  endfunction

  function automatic result_t tag_byte(logic [7:0] b, logic eol);
    result_t r;
    logic    colon_taken;
    r           = '0;
    r.out_byte  = b;
    r.field_kind = KIND_SEP;
    r.last      = eol;
    colon_taken = 1'b0;
    if (parse_ph == PH_START) begin
      at_start = 1'b1;
      if (b == CharColon) begin
        parse_ph    = PH_SRC;
        colon_taken = 1'b1;
      end else begin
        parse_ph = PH_CMD;
      end
    end
    if (!colon_taken) begin
      case (parse_ph)
        PH_SRC: begin
          if (b == CharBang) begin
            r.source_is_nick = 1'b1;
            close_field(PH_USER);
          end else if (b == CharSpace) close_field(PH_CMD);
          else mark_field(r, KIND_SRC);
        end
        PH_USER: begin
          if (b == CharAt) close_field(PH_HOST);
          else mark_field(r, KIND_USER);
        end
        PH_HOST: begin
          if (b == CharSpace) close_field(PH_CMD);
          else mark_field(r, KIND_HOST);
        end
        PH_CMD: begin
          if (b == CharSpace) close_field(PH_PARAM);
          else mark_field(r, KIND_CMD);
        end
        PH_PARAM: begin
          if (at_start && b == CharColon) begin
            if (param_cnt >= MaxParams) line_err = 1'b1;
            parse_ph = PH_TRAIL;
            at_start = 1'b1;
          end else if (b == CharSpace) begin
            if (!at_start && param_cnt < MaxParams) param_cnt++;
            at_start = 1'b1;
          end else begin
            if (at_start && param_cnt >= MaxParams) line_err = 1'b1;
            mark_field(r, KIND_MID);
            r.param_number = ParamNumW'(param_cnt);
          end
        end
        PH_TRAIL: begin
          mark_field(r, KIND_TRAIL);
          r.param_number = ParamNumW'(param_cnt);
        end
        default: begin
          parse_ph = PH_START;
          at_start = 1'b1;
        end
      endcase
    end
    // line cut short inside the prefix or before any command byte
    if (eol && (parse_ph == PH_SRC || parse_ph == PH_USER || parse_ph == PH_HOST ||
                (parse_ph == PH_CMD && at_start)))
      line_err = 1'b1;
    r.malformed = line_err;
    if (eol) begin
      parse_ph  = PH_START;
      param_cnt = 0;
      at_start  = 1'b1;
      line_err  = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    err_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (byte %02h)", name, got, want,
                                want_res.out_byte));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_tags_q.push_back(tag_byte(data_byte_i, line_end_i));
      if (!in_valid_i || in_ready_o) begin
        if (line_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = line_bytes_q.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_byte.data_byte;
          line_end_i  <= next_byte.line_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tags_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, byte %02h", out_byte_o));
        end else begin
          want_res = expected_tags_q.pop_front();
          check_field("out_byte", out_byte_o, want_res.out_byte);
          check_field("field_kind", 8'(field_kind_o), 8'(want_res.field_kind));
          check_field("param_number", 8'(param_number_o), 8'(want_res.param_number));
          check_field("field_start", 8'(field_start_o), 8'(want_res.field_start));
          check_field("source_is_nick", 8'(source_is_nick_o), 8'(want_res.source_is_nick));
          check_field("malformed", 8'(malformed_o), 8'(want_res.malformed));
          check_field("last", 8'(last_o), 8'(want_res.last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic flush_line();
    in_item_t it;
    while (text_q.size() > 0) begin
      it.data_byte = text_q.pop_front();
      it.line_end  = (text_q.size() == 0);
      line_bytes_q.push_back(it);
    end
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 85) return 8'($urandom_range(8'h61, 8'h7a));
    return 8'($urandom_range(255));
  endfunction

  task automatic add_word(int unsigned len);
    for (int unsigned i = 0; i < len; i++) text_q.push_back(rand_char());
  endtask

  task automatic add_random_line();
    int unsigned n_params;
    int unsigned cut;
    if ($urandom_range(99) < 15) begin
      // noise: separators and random bytes in no particular order
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(4))
          0: text_q.push_back(CharColon);
          1: text_q.push_back(CharSpace);
          2: text_q.push_back(CharBang);
          3: text_q.push_back(CharAt);
          default: text_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end else begin
      if ($urandom_range(99) < 70) begin
        text_q.push_back(CharColon);
        add_word(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5));
        if ($urandom_range(99) < 60) begin
          text_q.push_back(CharBang);
          add_word(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 4));
          text_q.push_back(CharAt);
          add_word(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5));
        end
        text_q.push_back(CharSpace);
      end
      add_word(($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6));
      n_params = ($urandom_range(99) < 88) ? $urandom_range(0, 4) : $urandom_range(13, 17);
      repeat (n_params) begin
        repeat ($urandom_range(99) < 15 ? 2 : 1) text_q.push_back(CharSpace);
        add_word($urandom_range(1, 3));
        if ($urandom_range(99) < 10) text_q.push_back(CharColon);
      end
      if ($urandom_range(99) < 50) begin
        text_q.push_back(CharSpace);
        text_q.push_back(CharColon);
        repeat ($urandom_range(0, 8)) begin
          case ($urandom_range(5))
            0: text_q.push_back(CharSpace);
            1: text_q.push_back(CharColon);
            default: text_q.push_back(rand_char());
          endcase
        end
      end
      // line ending early
      if ($urandom_range(99) < 10) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
    flush_line();
  endtask

  initial begin
    int unsigned idle_tab[3][2];
    int unsigned target;
    idle_tab = '{'{24, 67}, '{67, 24}, '{0, 0}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 3; p++) begin
      @(negedge clk_i);
      send_idle_pct  = idle_tab[p][0];
      recv_stall_pct = idle_tab[p][1];
      if (p == 0) begin
        add_text(":n!u@h C a:b  :t :"); flush_line();
        add_text(":s C");               flush_line();
        add_text(":");                  flush_line();
        add_text(" x");                 flush_line();
        text_q.push_back(8'hFF);
        text_q.push_back(8'h00);
        flush_line();
      end
      target = line_bytes_q.size() + 200;
      while (line_bytes_q.size() < target) add_random_line();
      while (line_bytes_q.size() != 0 || in_valid_i) @(negedge clk_i);
    end
    while (expected_tags_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_count == 0 && expected_tags_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== irc_message_tokenizer.f =====
src/imt_pkg.sv
src/imt_in_reg.sv
src/imt_core.sv
src/imt_out_reg.sv
src/irc_message_tokenizer.sv
tb/testbench.sv
